@@ src/dvvs_pkg.sv @@
`default_nettype none
package dvvs_pkg;

	// grid geometry; image and select fields are taken modulo the grid edge
	localparam int GRID_SIZE = 32;
	localparam int COORD_W   = $clog2(GRID_SIZE);
	localparam int GRID_MAX  = GRID_SIZE - 1;
	localparam int VOXELS    = GRID_SIZE * GRID_SIZE * GRID_SIZE;
	localparam int ADDR_W    = 3 * COORD_W;

	// voxel word layout
	localparam int SUM_W = 11;
	localparam int CNT_W = 3;
	localparam logic [CNT_W-1:0] MAX_HITS = 3'd7;

	// depth scaling: d = (2*code*GRID_MAX + 255) / 510 via reciprocal 2^25/510 rounded up
	localparam int DEPTH_NUM_W   = 16;
	localparam int DEPTH_RECIP_W = 17;
	localparam int DEPTH_SHIFT   = 25;
	localparam logic [DEPTH_RECIP_W-1:0] DEPTH_RECIP = 17'd65794;

	// average: (512*sum + n) / (2*n) via reciprocal 2^24/(2n) rounded up
	localparam int AVG_W     = 16;
	localparam int NUM_W     = SUM_W + 9;
	localparam int RECIP_W   = 24;
	localparam int AVG_SHIFT = 24;

	// reset values of the keep window
	localparam logic [7:0] KEEP_MIN_RESET = 8'd13;
	localparam logic [7:0] KEEP_MAX_RESET = 8'd242;

	// register indexes
	localparam logic REG_KEEP_MIN = 1'b0;
	localparam logic REG_KEEP_MAX = 1'b1;

	// opcodes
	localparam logic [1:0] OP_SPLAT = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// source views
	localparam logic [2:0] VIEW_NX = 3'd0;
	localparam logic [2:0] VIEW_NY = 3'd1;
	localparam logic [2:0] VIEW_NZ = 3'd2;
	localparam logic [2:0] VIEW_PX = 3'd3;
	localparam logic [2:0] VIEW_PY = 3'd4;
	localparam logic [2:0] VIEW_PZ = 3'd5;

	typedef struct packed {
		logic [1:0] opcode;
		logic [2:0] view_axis;
		logic [4:0] image_col;
		logic [4:0] image_row;
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
		logic [7:0] pixel_alpha;
		logic [4:0] sel_x;
		logic [4:0] sel_y;
		logic [4:0] sel_z;
	} in_item_t;

	typedef struct packed {
		logic        accepted;
		logic [4:0]  voxel_x;
		logic [4:0]  voxel_y;
		logic [4:0]  voxel_z;
		logic [2:0]  hit_count;
		logic [15:0] avg_red;
		logic [15:0] avg_green;
		logic [15:0] avg_blue;
	} out_item_t;

	typedef struct packed {
		logic [SUM_W-1:0] red;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] blue;
		logic [CNT_W-1:0] count;
	} voxel_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DEPTH,
		ST_ADDR,
		ST_UPDATE,
		ST_DIVIDE,
		ST_DONE
	} state_t;

	// reciprocal of twice the hit count; zero count gives a zero average
	function automatic logic [RECIP_W-1:0] avg_recip(input logic [CNT_W-1:0] count);
		logic [RECIP_W-1:0] r;
		case (count)
			3'd1:    r = 24'd8388608;
			3'd2:    r = 24'd4194304;
			3'd3:    r = 24'd2796203;
			3'd4:    r = 24'd2097152;
			3'd5:    r = 24'd1677722;
			3'd6:    r = 24'd1398102;
			3'd7:    r = 24'd1198373;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ src/dvvs_ram.sv @@
`default_nettype none
module dvvs_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 32768
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ src/depth_view_voxel_splat_average.sv @@
`default_nettype none
// Voxel splatting with color averaging over a 32x32x32 grid.
// Input channel (item_valid / item_stall / item): one transaction is a splat,
// read or clear command. Output channel (result_valid / result_stall /
// result): exactly one result transaction per command, in command order.
// Configuration: cfg_we writes cfg_data into the keep-window register chosen
// by cfg_index (0 min depth, 1 max depth); write only while the block is idle.
// One command is in flight at a time: a new command is taken only after
// the previous one has passed the depth, address, update, divide and done
// states, set by the read-modify-write of the single voxel memory followed
// by the average multiply stage; the done state waits on a stalled output.
// The result sits in an output register, so a stalled receiver holds the
// result while the next command is already taken and worked on; only its
// final load waits for the output register to drain.
// Reset: the voxel memory is cleared one entry per cycle, all 32768 entries,
// with item_stall high; configuration writes are taken during that pass.
module depth_view_voxel_splat_average
	import dvvs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	output logic           item_stall,
	input  wire in_item_t  item,
	output logic           result_valid,
	input  wire logic      result_stall,
	output out_item_t      result,
	input  wire logic      cfg_we,
	input  wire logic      cfg_index,
	input  wire logic [7:0] cfg_data
);

	state_t state_q, state_d;

	logic [7:0]        keep_min_q, keep_max_q;
	logic [ADDR_W-1:0] clr_q;
	in_item_t          item_q;

	logic              reject_q;
	logic [COORD_W-1:0] depth_q;
	logic [COORD_W-1:0] x_q, y_q, z_q;

	logic              res_acc_q;
	logic [COORD_W-1:0] res_x_q, res_y_q, res_z_q;
	voxel_t            res_vox_q;
	logic [AVG_W-1:0]  avg_red_q, avg_green_q, avg_blue_q;

	logic              result_valid_q;
	out_item_t         result_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	voxel_t            ram_wdata, ram_rdata;
	logic              load_out;

	// memory for color sums and hit counts
	dvvs_ram #(
		.WIDTH($bits(voxel_t)),
		.DEPTH(VOXELS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// keep window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_min_q <= KEEP_MIN_RESET;
			keep_max_q <= KEEP_MAX_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEEP_MIN: keep_min_q <= cfg_data;
				REG_KEEP_MAX: keep_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// depth code, window test and scaled depth coordinate
	logic [7:0]                           code;
	logic [DEPTH_NUM_W-1:0]               depth_num;
	logic [DEPTH_NUM_W+DEPTH_RECIP_W-1:0] depth_prod;
	logic                                 reject;

	always_comb begin
		code       = ~item_q.pixel_alpha;
		depth_num  = DEPTH_NUM_W'(code) * DEPTH_NUM_W'(2 * GRID_MAX) + DEPTH_NUM_W'(255);
		depth_prod = depth_num * DEPTH_RECIP;
		if (item_q.opcode == OP_SPLAT) begin
			reject = (code < keep_min_q) || (code > keep_max_q) || (item_q.view_axis > VIEW_PZ);
		end else begin
			reject = (item_q.opcode != OP_READ) && (item_q.opcode != OP_CLEAR);
		end
	end

	always_ff @(posedge clk) begin
		depth_q  <= depth_prod[DEPTH_SHIFT +: COORD_W];
		reject_q <= reject;
	end

	// voxel coordinates per view, or the selected voxel
	logic [COORD_W-1:0] c, r, nd, nc, nr;
	logic [COORD_W-1:0] map_x, map_y, map_z;

	always_comb begin
		c  = item_q.image_col[COORD_W-1:0];
		r  = item_q.image_row[COORD_W-1:0];
		nd = COORD_W'(GRID_MAX) - depth_q;
		nc = COORD_W'(GRID_MAX) - c;
		nr = COORD_W'(GRID_MAX) - r;
		if (item_q.opcode == OP_SPLAT) begin
			case (item_q.view_axis)
				VIEW_NX: begin map_x = nd;      map_y = c;       map_z = r;  end
				VIEW_NY: begin map_x = nr;      map_y = nc;      map_z = depth_q; end
				VIEW_NZ: begin map_x = nc;      map_y = nd;      map_z = r;  end
				VIEW_PX: begin map_x = depth_q; map_y = nc;      map_z = r;  end
				VIEW_PY: begin map_x = nr;      map_y = c;       map_z = nd; end
				default: begin map_x = c;       map_y = depth_q; map_z = r;  end
			endcase
		end else begin
			map_x = item_q.sel_x[COORD_W-1:0];
			map_y = item_q.sel_y[COORD_W-1:0];
			map_z = item_q.sel_z[COORD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		x_q <= map_x;
		y_q <= map_y;
		z_q <= map_z;
	end

	// read-modify-write of the voxel word
	voxel_t new_vox;
	logic   upd_we;

	always_comb begin
		new_vox = ram_rdata;
		upd_we  = 1'b0;
		if (!reject_q) begin
			case (item_q.opcode)
				OP_SPLAT: begin
					if (ram_rdata.count < MAX_HITS) begin
						upd_we        = 1'b1;
						new_vox.red   = ram_rdata.red + SUM_W'(item_q.pixel_red);
						new_vox.green = ram_rdata.green + SUM_W'(item_q.pixel_green);
						new_vox.blue  = ram_rdata.blue + SUM_W'(item_q.pixel_blue);
						new_vox.count = ram_rdata.count + CNT_W'(1);
					end
				end
				OP_CLEAR: begin
					upd_we  = 1'b1;
					new_vox = '0;
				end
				default: ;
			endcase
		end
	end

	// result word captured at the update step
	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE) begin
			res_acc_q <= !reject_q;
			res_x_q   <= reject_q ? '0 : x_q;
			res_y_q   <= reject_q ? '0 : y_q;
			res_z_q   <= reject_q ? '0 : z_q;
			res_vox_q <= reject_q ? '0 : new_vox;
		end
	end

	// averages by reciprocal multiply
	logic [RECIP_W-1:0]       recip;
	logic [NUM_W+RECIP_W-1:0] prod_red, prod_green, prod_blue;

	always_comb begin
		recip      = avg_recip(res_vox_q.count);
		prod_red   = {res_vox_q.red, 6'd0, res_vox_q.count} * recip;
		prod_green = {res_vox_q.green, 6'd0, res_vox_q.count} * recip;
		prod_blue  = {res_vox_q.blue, 6'd0, res_vox_q.count} * recip;
	end

	always_ff @(posedge clk) begin
		avg_red_q   <= prod_red[AVG_SHIFT +: AVG_W];
		avg_green_q <= prod_green[AVG_SHIFT +: AVG_W];
		avg_blue_q  <= prod_blue[AVG_SHIFT +: AVG_W];
	end

	// command sequencer
	always_comb begin
		state_d    = state_q;
		ram_we     = 1'b0;
		ram_waddr  = {x_q, y_q, z_q};
		ram_wdata  = new_vox;
		ram_raddr  = {map_x, map_y, map_z};
		load_out   = 1'b0;
		item_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == ADDR_W'(VOXELS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					state_d = ST_DEPTH;
				end
			end
			ST_DEPTH:  state_d = ST_ADDR;
			ST_ADDR:   state_d = ST_UPDATE;
			ST_UPDATE: begin
				ram_we  = upd_we;
				state_d = ST_DIVIDE;
			end
			ST_DIVIDE: state_d = ST_DONE;
			ST_DONE: begin
				if (!result_valid_q || !result_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
		end
	end

	// command capture
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_q <= item;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q.accepted  <= res_acc_q;
			result_q.voxel_x   <= 5'(res_x_q);
			result_q.voxel_y   <= 5'(res_y_q);
			result_q.voxel_z   <= 5'(res_z_q);
			result_q.hit_count <= res_vox_q.count;
			result_q.avg_red   <= avg_red_q;
			result_q.avg_green <= avg_green_q;
			result_q.avg_blue  <= avg_blue_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

@@ sim/depth_view_voxel_splat_average_tb.sv @@
`timescale 1ns / 1ps
module depth_view_voxel_splat_average_tb;
	import dvvs_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RUN_LIMIT_NS = 10_000_000;
	localparam int IN_W = $bits(in_item_t);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	in_item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_item_t result;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_KEEP_MIN;
	logic [7:0] cfg_data = '0;

	// commands waiting to go out and voxel reports still owed by the block
	in_item_t commands_to_send[$];
	out_item_t voxel_reports_due[$];

	// shadow of the voxel store and keep window
	bit [SUM_W-1:0] red_sum [VOXELS];
	bit [SUM_W-1:0] green_sum [VOXELS];
	bit [SUM_W-1:0] blue_sum [VOXELS];
	bit [CNT_W-1:0] hits [VOXELS];
	logic [7:0] keep_min = KEEP_MIN_RESET;
	logic [7:0] keep_max = KEEP_MAX_RESET;

	// stimulus side view of the window, hot splat spots and recently touched voxels
	int unsigned gen_min = KEEP_MIN_RESET;
	int unsigned gen_max = KEEP_MAX_RESET;
	logic [2:0] hot_view [3];
	logic [4:0] hot_col [3];
	logic [4:0] hot_row [3];
	logic [7:0] hot_alpha [3];
	logic [ADDR_W-1:0] touched_voxels[$];

	bit idle_on = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	bit cmd_taken = 1'b0;
	int mismatches = 0;

	depth_view_voxel_splat_average u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	// voxel hit by a pixel of a given view and depth
	function automatic logic [ADDR_W-1:0] splat_target(logic [2:0] view, logic [4:0] col,
			logic [4:0] row, logic [7:0] alpha);
		int unsigned code, d;
		logic [4:0] dd, x, y, z;
		code = 255 - alpha;
		d = (2 * code * GRID_MAX + 255) / 510;
		dd = 5'(d);
		case (view)
			VIEW_NX: begin x = 5'(GRID_MAX) - dd; y = col; z = row; end
			VIEW_NY: begin x = 5'(GRID_MAX) - row; y = 5'(GRID_MAX) - col; z = dd; end
			VIEW_NZ: begin x = 5'(GRID_MAX) - col; y = 5'(GRID_MAX) - dd; z = row; end
			VIEW_PX: begin x = dd; y = 5'(GRID_MAX) - col; z = row; end
			VIEW_PY: begin x = 5'(GRID_MAX) - row; y = col; z = 5'(GRID_MAX) - dd; end
			default: begin x = col; y = dd; z = row; end
		endcase
		return {x, y, z};
	endfunction

	// unsigned 8.8 average rounded half up
	function automatic logic [AVG_W-1:0] avg_8p8(bit [SUM_W-1:0] sum, bit [CNT_W-1:0] cnt);
		int unsigned s, n;
		s = sum;
		n = cnt;
		if (n == 0)
			return '0;
		return 16'((s * 512 + n) / (2 * n));
	endfunction

	function automatic out_item_t voxel_report(logic [ADDR_W-1:0] addr);
		out_item_t rep;
		rep.accepted = 1'b1;
		{rep.voxel_x, rep.voxel_y, rep.voxel_z} = addr;
		rep.hit_count = hits[addr];
		rep.avg_red = avg_8p8(red_sum[addr], hits[addr]);
		rep.avg_green = avg_8p8(green_sum[addr], hits[addr]);
		rep.avg_blue = avg_8p8(blue_sum[addr], hits[addr]);
		return rep;
	endfunction

	// apply one command to the shadow store and return the report it yields
	function automatic out_item_t splat_and_report(in_item_t cmd);
		out_item_t rep;
		logic [ADDR_W-1:0] addr;
		int unsigned code;
		rep = '0;
		case (cmd.opcode)
			OP_READ, OP_CLEAR: begin
				addr = {cmd.sel_x, cmd.sel_y, cmd.sel_z};
				if (cmd.opcode == OP_CLEAR) begin
					red_sum[addr] = '0;
					green_sum[addr] = '0;
					blue_sum[addr] = '0;
					hits[addr] = '0;
				end
				rep = voxel_report(addr);
			end
			OP_SPLAT: begin
				code = 255 - cmd.pixel_alpha;
				if (code >= keep_min && code <= keep_max && cmd.view_axis <= VIEW_PZ) begin
					addr = splat_target(cmd.view_axis, cmd.image_col, cmd.image_row,
						cmd.pixel_alpha);
					if (hits[addr] != MAX_HITS) begin
						red_sum[addr] = red_sum[addr] + cmd.pixel_red;
						green_sum[addr] = green_sum[addr] + cmd.pixel_green;
						blue_sum[addr] = blue_sum[addr] + cmd.pixel_blue;
						hits[addr] = hits[addr] + 1'b1;
					end
					rep = voxel_report(addr);
				end
			end
			default: ;
		endcase
		return rep;
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	function automatic int pick_gap();
		int unsigned roll;
		if (!idle_on)
			return 0;
		roll = $urandom_range(99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// command builders; fields the opcode ignores get random values
	function automatic in_item_t splat_cmd(logic [2:0] view, logic [4:0] col, logic [4:0] row,
			logic [7:0] red, logic [7:0] green, logic [7:0] blue, logic [7:0] alpha);
		in_item_t cmd;
		cmd = IN_W'({$urandom(), $urandom()});
		cmd.opcode = OP_SPLAT;
		cmd.view_axis = view;
		cmd.image_col = col;
		cmd.image_row = row;
		cmd.pixel_red = red;
		cmd.pixel_green = green;
		cmd.pixel_blue = blue;
		cmd.pixel_alpha = alpha;
		return cmd;
	endfunction

	function automatic in_item_t select_cmd(logic [1:0] op, logic [ADDR_W-1:0] addr);
		in_item_t cmd;
		cmd = IN_W'({$urandom(), $urandom()});
		cmd.opcode = op;
		{cmd.sel_x, cmd.sel_y, cmd.sel_z} = addr;
		return cmd;
	endfunction

	// append a command to the send queue
	function automatic void queue_cmd(in_item_t cmd);
		commands_to_send = {commands_to_send, cmd};
	endfunction

	function automatic void remember_voxel(logic [ADDR_W-1:0] addr);
		touched_voxels = {touched_voxels, addr};
		if (touched_voxels.size() > 16)
			void'(touched_voxels.pop_front());
	endfunction

	function automatic logic [ADDR_W-1:0] pick_voxel();
		if (touched_voxels.size() != 0 && $urandom_range(9) < 7)
			return touched_voxels[$urandom_range(touched_voxels.size() - 1)];
		return ADDR_W'($urandom());
	endfunction

	task automatic queue_directed();
		logic [ADDR_W-1:0] spot;
		// window edges: codes 255 and 0 rejected, 13 and 242 kept, 243 and 12 rejected
		queue_cmd(splat_cmd(VIEW_NX, 5'd0, 5'd31, 8'd255, 8'd0, 8'd128, 8'd0));
		queue_cmd(splat_cmd(VIEW_NY, 5'd31, 5'd0, 8'd1, 8'd2, 8'd3, 8'd255));
		queue_cmd(splat_cmd(VIEW_NX, 5'd31, 5'd0, 8'd255, 8'd0, 8'd128, 8'd242));
		queue_cmd(splat_cmd(VIEW_NY, 5'd0, 5'd31, 8'd0, 8'd255, 8'd7, 8'd13));
		queue_cmd(splat_cmd(VIEW_NZ, 5'd3, 5'd4, 8'd9, 8'd9, 8'd9, 8'd12));
		queue_cmd(splat_cmd(VIEW_PX, 5'd3, 5'd4, 8'd9, 8'd9, 8'd9, 8'd243));
		// remaining views, then the two undefined ones
		queue_cmd(splat_cmd(VIEW_NZ, 5'd31, 5'd0, 8'd10, 8'd20, 8'd30, 8'd128));
		queue_cmd(splat_cmd(VIEW_PX, 5'd0, 5'd31, 8'd40, 8'd50, 8'd60, 8'd128));
		queue_cmd(splat_cmd(VIEW_PY, 5'd31, 5'd0, 8'd70, 8'd80, 8'd90, 8'd128));
		queue_cmd(splat_cmd(VIEW_PZ, 5'd0, 5'd31, 8'd11, 8'd22, 8'd33, 8'd128));
		queue_cmd(splat_cmd(3'd6, 5'd1, 5'd1, 8'd5, 8'd5, 8'd5, 8'd128));
		queue_cmd(splat_cmd(3'd7, 5'd1, 5'd1, 8'd5, 8'd5, 8'd5, 8'd128));
		// eight full-scale hits on one voxel: the last one finds it saturated
		spot = splat_target(VIEW_PZ, 5'd5, 5'd9, 8'd100);
		repeat (8)
			queue_cmd(splat_cmd(VIEW_PZ, 5'd5, 5'd9, 8'd255, 8'd255, 8'd255, 8'd100));
		queue_cmd(select_cmd(OP_READ, spot));
		queue_cmd(select_cmd(OP_CLEAR, spot));
		queue_cmd(select_cmd(OP_READ, spot));
		queue_cmd(select_cmd(OP_UNUSED, ADDR_W'($urandom())));
		queue_cmd(select_cmd(OP_READ, '1));
		queue_cmd(select_cmd(OP_READ, '0));
		queue_cmd(select_cmd(OP_READ, splat_target(VIEW_NX, 5'd31, 5'd0, 8'd242)));
	endtask

	task automatic queue_random(int count);
		int unsigned roll, h;
		in_item_t cmd;
		// a few hot spots per chunk so voxels fill up and saturate
		for (int i = 0; i < 3; i++) begin
			hot_view[i] = 3'($urandom_range(5));
			hot_col[i] = 5'($urandom());
			hot_row[i] = 5'($urandom());
			if (gen_min <= gen_max)
				hot_alpha[i] = 8'(255 - $urandom_range(gen_max, gen_min));
			else
				hot_alpha[i] = 8'($urandom());
		end
		for (int k = 0; k < count; k++) begin
			roll = $urandom_range(99);
			if (roll < 60) begin
				if ($urandom_range(9) < 6) begin
					h = $urandom_range(2);
					cmd = splat_cmd(hot_view[h], hot_col[h], hot_row[h], 8'($urandom()),
						8'($urandom()), 8'($urandom()), hot_alpha[h]);
				end else begin
					cmd = IN_W'({$urandom(), $urandom()});
					cmd.opcode = OP_SPLAT;
					cmd.view_axis = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
						: 3'($urandom_range(5));
				end
				if (cmd.view_axis <= VIEW_PZ)
					remember_voxel(splat_target(cmd.view_axis, cmd.image_col, cmd.image_row,
						cmd.pixel_alpha));
			end else if (roll < 80)
				cmd = select_cmd(OP_READ, pick_voxel());
			else if (roll < 95)
				cmd = select_cmd(OP_CLEAR, pick_voxel());
			else
				cmd = select_cmd(OP_UNUSED, ADDR_W'($urandom()));
			queue_cmd(cmd);
		end
	endtask

	// hold off until every command is out and every report is back
	task automatic drain();
		while (commands_to_send.size() != 0 || item_valid || voxel_reports_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_window(int unsigned lo, int unsigned hi);
		write_reg(REG_KEEP_MIN, 8'(lo));
		write_reg(REG_KEEP_MAX, 8'(hi));
		gen_min = lo;
		gen_max = hi;
	endtask

	// command driver
	always @(negedge clk) begin
		if (arst_n && (!item_valid || cmd_taken)) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				item_valid <= 1'b0;
			end else if (commands_to_send.size() != 0) begin
				item <= commands_to_send.pop_front();
				item_valid <= 1'b1;
				send_gap <= pick_gap();
			end else
				item_valid <= 1'b0;
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
			if ($urandom_range(3) == 0)
				stall_left <= pick_gap();
		end
	end

	// check reports, predict accepted commands, track register writes
	always @(posedge clk) begin : track_block
		out_item_t due;
		cmd_taken <= item_valid && !item_stall;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (voxel_reports_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result transaction, expected none actual %h",
						$time, result);
				end else begin
					due = voxel_reports_due.pop_front();
					check_field("accepted", 16'(due.accepted), 16'(result.accepted));
					check_field("voxel_x", 16'(due.voxel_x), 16'(result.voxel_x));
					check_field("voxel_y", 16'(due.voxel_y), 16'(result.voxel_y));
					check_field("voxel_z", 16'(due.voxel_z), 16'(result.voxel_z));
					check_field("hit_count", 16'(due.hit_count), 16'(result.hit_count));
					check_field("avg_red", due.avg_red, result.avg_red);
					check_field("avg_green", due.avg_green, result.avg_green);
					check_field("avg_blue", due.avg_blue, result.avg_blue);
				end
			end
			if (item_valid && !item_stall)
				voxel_reports_due = {voxel_reports_due, splat_and_report(item)};
			if (cfg_we) begin
				if (cfg_index == REG_KEEP_MIN)
					keep_min = cfg_data;
				else
					keep_max = cfg_data;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed pass at the reset window, no idling
		queue_directed();
		drain();

		// random traffic at the reset window, second chunk without idling
		idle_on = 1'b1;
		queue_random(80);
		drain();
		idle_on = 1'b0;
		queue_random(60);
		drain();
		idle_on = 1'b1;

		// full window
		set_window(0, 255);
		queue_random(80);
		drain();
		queue_random(60);
		drain();

		// inverted window rejects every splat
		set_window(255, 0);
		queue_random(50);
		drain();

		// single-code window
		set_window(100, 100);
		queue_random(60);
		drain();

		// a few random windows
		repeat (3) begin
			set_window($urandom_range(120), $urandom_range(255, 130));
			queue_random(60);
			drain();
		end

		// back to narrow edges of the code range
		set_window(0, 0);
		queue_random(30);
		drain();
		set_window(255, 255);
		queue_random(30);
		drain();

		if (mismatches == 0)
			$display("depth_view_voxel_splat_average_tb passed");
		else
			$display("depth_view_voxel_splat_average_tb failed");
		$finish;
	end

	// run time limit
	initial begin
		#(RUN_LIMIT_NS);
		$display("depth_view_voxel_splat_average_tb failed");
		$finish;
	end

endmodule
